### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the position converter.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");
// condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### hw/rtl/g2e_pkg.sv
// Types, fixed-point constants and elaboration-time table builders for the
// geodetic to ENU converter. No dependencies.
package g2e_pkg;

   // register stages of the pipelined multiplier and derived blocks
   localparam int FMUL_LAT   = 5;
   localparam int NEWTON_LAT = 3 * FMUL_LAT + 1;
   localparam int ECEF_LAT   = 5 * FMUL_LAT + 2 + 6 * NEWTON_LAT;

   // Q60 values
   localparam logic signed [63:0] ONE_Q60   = 64'sh1000_0000_0000_0000;
   localparam logic signed [63:0] THREE_Q60 = 64'sh3000_0000_0000_0000;
   localparam logic signed [63:0] GAIN_SEED = THREE_Q60 / 5;
   localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] DEG_DEN = 64'd1800000000;
   localparam logic [63:0] RAD_K   = ((PI_Q60 / DEG_DEN) << 32) +
                                     (((PI_Q60 % DEG_DEN) << 32) / DEG_DEN);

   // angle folding in 1e-7 degree
   localparam logic signed [32:0] HALF_TURN    = 33'sd1800000000;
   localparam logic signed [32:0] QUARTER_TURN = 33'sd900000000;

   // flattening 1/298.257223563 in Q60, by long division in three pieces
   localparam logic [63:0] FLAT_DEN = 64'd298257223563;
   localparam logic [63:0] FLAT_A   = 64'd1000000000 << 24;
   localparam logic [63:0] FLAT_Q1  = FLAT_A / FLAT_DEN;
   localparam logic [63:0] FLAT_R1  = FLAT_A % FLAT_DEN;
   localparam logic [63:0] FLAT_Q2  = (FLAT_R1 << 24) / FLAT_DEN;
   localparam logic [63:0] FLAT_R2  = (FLAT_R1 << 24) % FLAT_DEN;
   localparam logic [63:0] FLAT_Q3  = (FLAT_R2 << 12) / FLAT_DEN;
   localparam logic signed [63:0] FLAT_Q60 = (FLAT_Q1 << 36) + (FLAT_Q2 << 12) + FLAT_Q3;

   // semi-major axis in Q16 millimetres
   localparam logic signed [63:0] SEMI_MAJOR_Q16 = 64'sd6378137000 <<< 16;

   // output saturation in millimetres
   localparam logic signed [63:0] OUT_LIMIT = 64'sd13000000000;

   typedef struct packed {
      logic signed [63:0] sin_val;
      logic signed [63:0] cos_val;
   } sincos_type;

   // unsigned long division, elaboration only
   function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(a*b/2^s), magnitude half away from zero, saturating; elaboration only
   function automatic logic signed [63:0] cfmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int s);
      logic         neg;
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [127:0] shifted;
      neg  = a[63] ^ b[63];
      ua   = a[63] ? (64'd0 - a) : a;
      ub   = b[63] ? (64'd0 - b) : b;
      prod = '0;
      for (int k = 0; k < 64; k++) begin
         if (ub[k]) prod = prod + ({64'd0, ua} << k);
      end
      shifted = (prod + (128'd1 << (s - 1))) >> s;
      if (|shifted[127:63]) mag = 64'h7FFF_FFFF_FFFF_FFFF;
      else mag = shifted[63:0];
      return neg ? (64'd0 - mag) : mag;
   endfunction

   // inverse square root by six Newton steps; elaboration only
   function automatic logic signed [63:0] crsqrt(input logic signed [63:0] v,
                                                 input logic signed [63:0] y0);
      logic signed [63:0] y;
      logic signed [63:0] t;
      y = y0;
      for (int k = 0; k < 6; k++) begin
         t = cfmul(v, cfmul(y, y, 60), 60);
         y = cfmul(y, THREE_Q60 - t, 61);
      end
      return y;
   endfunction

   // CORDIC gain inverse for a given number of micro-rotations
   function automatic logic signed [63:0] gain_inv_calc(input int iters);
      logic signed [63:0] p;
      p = ONE_Q60;
      for (int i = 0; i < 62; i++) begin
         if (i < iters && 2 * i < 62) p = p + (p >>> (2 * i));
      end
      return crsqrt(p, GAIN_SEED);
   endfunction

   // arctangent entries: pi/4 first, then truncated Taylor series
   function automatic logic signed [63:0] atan_entry(input int i);
      logic signed [63:0] sum;
      logic [63:0]        term;
      int                 m;
      sum = '0;
      if (i == 0) begin
         sum = (PI_Q60 + 64'd2) >> 2;
      end else begin
         for (int k = 0; k < 31; k++) begin
            m = 2 * k + 1;
            if (m * i <= 60) begin
               term = cdiv(64'd1 << (60 - m * i), 64'(m));
               if (k % 2 == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   localparam logic signed [63:0] ECC2       = cfmul(FLAT_Q60, 2 * ONE_Q60 - FLAT_Q60, 60);
   localparam logic signed [63:0] ONE_M_ECC2 = ONE_Q60 - ECC2;

endpackage

### hw/rtl/g2e_delay.sv
// Enabled shift line that keeps side values aligned with the multiplier stages.
// No dependencies.
module g2e_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   // advance the whole line on enable
   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) stage_ff[k] <= stage_ff[k-1];
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule

### hw/rtl/g2e_fmul.sv
// Pipelined signed 64x64 fixed-point multiply with rounding and saturation,
// built from four 32x32 partial products. No dependencies.
module g2e_fmul #(
   parameter int SHIFT = 60
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] y
);

   localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

   logic         neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [63:0]  ua_ff, ub_ff;
   logic [63:0]  ua_in, ub_in;
   logic [63:0]  p00_in, p01_in, p10_in, p11_in;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum_ff, sum_in;
   logic [127:0] rnd_in;
   logic [63:0]  mag_ff, mag_in;
   logic signed [63:0] y_ff;

   // split into sign and magnitudes
   assign ua_in = a[63] ? (64'd0 - a) : a;
   assign ub_in = b[63] ? (64'd0 - b) : b;

   // partial products
   assign p00_in = ua_ff[31:0]  * ub_ff[31:0];
   assign p01_in = ua_ff[31:0]  * ub_ff[63:32];
   assign p10_in = ua_ff[63:32] * ub_ff[31:0];
   assign p11_in = ua_ff[63:32] * ub_ff[63:32];

   // full product
   assign sum_in = {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} +
                   {32'd0, p10_ff, 32'd0} + {p11_ff, 64'd0};

   // round, scale and clamp the magnitude
   assign rnd_in = (sum_ff + RND) >> SHIFT;
   assign mag_in = (|rnd_in[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : rnd_in[63:0];

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a[63] ^ b[63];
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg2_ff <= neg1_ff;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg3_ff <= neg2_ff;
         sum_ff  <= sum_in;
         neg4_ff <= neg3_ff;
         mag_ff  <= mag_in;
         y_ff    <= neg4_ff ? (64'd0 - mag_ff) : mag_ff;
      end
   end

   assign y = y_ff;

endmodule

### hw/rtl/g2e_newton.sv
// One pipelined Newton step of the inverse square root: y * (3 - v*y*y) / 2.
// Depends on g2e_pkg, g2e_fmul and g2e_delay.
module g2e_newton import g2e_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] v,
   input  logic signed [63:0] y,
   output logic signed [63:0] v_out,
   output logic signed [63:0] y_out
);

   logic signed [63:0] yy, t, v_d1, y_d;
   logic signed [63:0] k_ff;

   g2e_fmul #(.SHIFT(60)) u_sq (.clock(clock), .en(en), .a(y), .b(y), .y(yy));

   g2e_delay #(.WIDTH(64), .DEPTH(FMUL_LAT)) u_v1 (
      .clock(clock), .en(en), .d(v), .q(v_d1));

   g2e_fmul #(.SHIFT(60)) u_vt (.clock(clock), .en(en), .a(v_d1), .b(yy), .y(t));

   // correction factor
   always_ff @(posedge clock) begin
      if (en) k_ff <= THREE_Q60 - t;
   end

   g2e_delay #(.WIDTH(64), .DEPTH(2 * FMUL_LAT + 1)) u_y (
      .clock(clock), .en(en), .d(y), .q(y_d));

   g2e_fmul #(.SHIFT(61)) u_upd (.clock(clock), .en(en), .a(y_d), .b(k_ff), .y(y_out));

   g2e_delay #(.WIDTH(64), .DEPTH(2 * FMUL_LAT + 1)) u_v2 (
      .clock(clock), .en(en), .d(v_d1), .q(v_out));

endmodule

### hw/rtl/g2e_sincos.sv
// Sine and cosine of an angle in 1e-7 degree: fold, scale to Q60 radians,
// then one CORDIC micro-rotation per stage. Depends on g2e_pkg, g2e_fmul, g2e_delay.
module g2e_sincos import g2e_pkg::*; #(
   parameter int ITERS = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] angle,
   output sincos_type         trig
);

   localparam logic signed [63:0] GAIN_INV = gain_inv_calc(ITERS);

   logic signed [32:0] ang_ext;
   logic signed [32:0] v_in, v_ff;
   logic               flip_in, flip_ff;
   logic [0:0]         flip_d;
   logic signed [63:0] z_mul;
   logic signed [63:0] x_ff [ITERS];
   logic signed [63:0] y_ff [ITERS];
   logic signed [63:0] z_ff [ITERS];
   sincos_type         trig_ff;

   // fold into +-90 degrees, remember to negate
   assign ang_ext = {angle[31], angle};
   always_comb begin
      v_in    = ang_ext;
      flip_in = 1'b0;
      if (ang_ext > QUARTER_TURN) begin
         v_in    = ang_ext - HALF_TURN;
         flip_in = 1'b1;
      end else if (ang_ext < -QUARTER_TURN) begin
         v_in    = ang_ext + HALF_TURN;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_in;
         flip_ff <= flip_in;
      end
   end

   // scale to Q60 radians
   g2e_fmul #(.SHIFT(32)) u_rad (
      .clock(clock), .en(en), .a({{31{v_ff[32]}}, v_ff}), .b(RAD_K), .y(z_mul));

   g2e_delay #(.WIDTH(1), .DEPTH(FMUL_LAT + ITERS)) u_flip (
      .clock(clock), .en(en), .d(flip_ff), .q(flip_d));

   // one micro-rotation per stage
   for (genvar i = 0; i < ITERS; i++) begin : g_rot
      localparam logic signed [63:0] ATAN_I = atan_entry(i);
      logic signed [63:0] x_src, y_src, z_src;
      if (i == 0) begin : g_first
         assign x_src = GAIN_INV;
         assign y_src = '0;
         assign z_src = z_mul;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_src[63]) begin
               x_ff[i] <= x_src - (y_src >>> i);
               y_ff[i] <= y_src + (x_src >>> i);
               z_ff[i] <= z_src - ATAN_I;
            end else begin
               x_ff[i] <= x_src + (y_src >>> i);
               y_ff[i] <= y_src - (x_src >>> i);
               z_ff[i] <= z_src + ATAN_I;
            end
         end
      end
   end

   // undo the fold
   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff.sin_val <= flip_d[0] ? -y_ff[ITERS-1] : y_ff[ITERS-1];
         trig_ff.cos_val <= flip_d[0] ? -x_ff[ITERS-1] : x_ff[ITERS-1];
      end
   end

   assign trig = trig_ff;

endmodule

### hw/rtl/g2e_ecef.sv
// Earth-centred coordinates in Q16 millimetres from latitude and longitude
// trig values and altitude. Depends on g2e_pkg, g2e_fmul, g2e_newton, g2e_delay.
module g2e_ecef import g2e_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  sincos_type         trig_lat,
   input  sincos_type         trig_lon,
   input  logic signed [27:0] alt,
   output logic signed [63:0] pos_x,
   output logic signed [63:0] pos_y,
   output logic signed [63:0] pos_z
);

   localparam int FL  = FMUL_LAT;
   localparam int T_R = 2 * FL + 1 + 6 * NEWTON_LAT;
   localparam int T1  = T_R + FL;

   logic signed [63:0] h;
   logic signed [63:0] h_d1, h_d2;
   logic signed [63:0] s2, t;
   logic signed [63:0] w_ff;
   logic signed [63:0] v_chain [6];
   logic signed [63:0] y_chain [7];
   logic signed [63:0] n, qn, rc;
   logic signed [63:0] nh_ff, qz_ff;
   logic signed [63:0] cl_d;
   logic [191:0]       side_d;

   assign h = {{20{alt[27]}}, alt, 16'd0};

   // 1 - e2 * sin^2(lat)
   g2e_fmul #(.SHIFT(60)) u_s2 (
      .clock(clock), .en(en), .a(trig_lat.sin_val), .b(trig_lat.sin_val), .y(s2));
   g2e_fmul #(.SHIFT(60)) u_es (.clock(clock), .en(en), .a(ECC2), .b(s2), .y(t));

   always_ff @(posedge clock) begin
      if (en) w_ff <= ONE_Q60 - t;
   end

   // inverse square root, six Newton steps from one
   assign v_chain[0] = w_ff;
   assign y_chain[0] = ONE_Q60;
   for (genvar i = 0; i < 6; i++) begin : g_newt
      if (i < 5) begin : g_mid
         g2e_newton u_step (
            .clock(clock), .en(en), .v(v_chain[i]), .y(y_chain[i]),
            .v_out(v_chain[i+1]), .y_out(y_chain[i+1]));
      end else begin : g_last
         g2e_newton u_step (
            .clock(clock), .en(en), .v(v_chain[i]), .y(y_chain[i]),
            .v_out(), .y_out(y_chain[i+1]));
      end
   end

   // prime vertical radius
   g2e_fmul #(.SHIFT(60)) u_n (
      .clock(clock), .en(en), .a(SEMI_MAJOR_Q16), .b(y_chain[6]), .y(n));

   g2e_delay #(.WIDTH(64), .DEPTH(T1)) u_h1 (.clock(clock), .en(en), .d(h), .q(h_d1));
   g2e_delay #(.WIDTH(64), .DEPTH(FL)) u_h2 (.clock(clock), .en(en), .d(h_d1), .q(h_d2));

   g2e_fmul #(.SHIFT(60)) u_qn (.clock(clock), .en(en), .a(n), .b(ONE_M_ECC2), .y(qn));

   // add height to both radii
   always_ff @(posedge clock) begin
      if (en) begin
         nh_ff <= n + h_d1;
         qz_ff <= qn + h_d2;
      end
   end

   g2e_delay #(.WIDTH(64), .DEPTH(T1 + 1)) u_cl (
      .clock(clock), .en(en), .d(trig_lat.cos_val), .q(cl_d));
   g2e_delay #(.WIDTH(192), .DEPTH(T1 + FL + 1)) u_side (
      .clock(clock), .en(en),
      .d({trig_lat.sin_val, trig_lon.cos_val, trig_lon.sin_val}), .q(side_d));

   g2e_fmul #(.SHIFT(60)) u_rc (.clock(clock), .en(en), .a(nh_ff), .b(cl_d), .y(rc));

   // project onto the axes
   g2e_fmul #(.SHIFT(60)) u_px (
      .clock(clock), .en(en), .a(rc), .b(side_d[127:64]), .y(pos_x));
   g2e_fmul #(.SHIFT(60)) u_py (
      .clock(clock), .en(en), .a(rc), .b(side_d[63:0]), .y(pos_y));
   g2e_fmul #(.SHIFT(60)) u_pz (
      .clock(clock), .en(en), .a(qz_ff), .b(side_d[191:128]), .y(pos_z));

endmodule

### hw/rtl/geodetic_to_enu.sv
// WGS84 geodetic position to local East/North/Up offsets in millimetres.
// Depends on g2e_pkg, g2e_sincos, g2e_ecef, g2e_fmul, g2e_delay, assert_macros.svh.

// Takes one position word per clock unless stalled and returns one
// east/north/up word per word, in order. The point and the reference each
// pass a CORDIC of ANGLE_ITERATIONS stages, a Newton inverse square root of
// six steps, and a chain of five-stage 64-bit multipliers; all of it is one
// enabled pipeline, so the sustained rate is one word per cycle unless stalled.
// rsp_stall freezes the pipeline while a finished word waits, and req_stall
// follows it. The user must write the reference registers through the csr
// port only while no word is in flight; the block itself does not enforce it.

`include "assert_macros.svh"

module geodetic_to_enu import g2e_pkg::*; #(
   parameter int ANGLE_ITERATIONS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_latitude,
   input  logic signed [31:0] req_longitude,
   input  logic signed [27:0] req_altitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [34:0] rsp_east,
   output logic signed [34:0] rsp_north,
   output logic signed [34:0] rsp_up,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam logic [1:0] CSR_REF_LATITUDE  = 2'd0;
   localparam logic [1:0] CSR_REF_LONGITUDE = 2'd1;
   localparam logic [1:0] CSR_REF_ALTITUDE  = 2'd2;

   localparam int FL   = FMUL_LAT;
   localparam int T_SC = ANGLE_ITERATIONS + FL + 2;
   localparam int LAT  = T_SC + ECEF_LAT + FL + 3;
   localparam logic signed [34:0] OUT_LIMIT_35 = 35'sd13000000000;

   logic               adv;
   logic [LAT-1:0]     valid_ff;
   logic signed [30:0] ref_latitude_ff;
   logic signed [31:0] ref_longitude_ff;
   logic signed [27:0] ref_altitude_ff;
   sincos_type         pt_lat, pt_lon, rf_lat, rf_lon;
   logic [27:0]        pt_alt_d, rf_alt_d;
   logic signed [63:0] pp_x, pp_y, pp_z, rp_x, rp_y, rp_z;
   logic signed [63:0] d0_ff, d1_ff, d2_ff;
   logic [255:0]       rt_early, rt_late;
   logic signed [63:0] spcl, spsl, cpcl, cpsl;
   logic signed [63:0] e0, e1, n0, n1, n2, u0, u1, u2;
   logic signed [63:0] e_sum_ff, n_sum_ff, u_sum_ff;
   logic signed [34:0] east_ff, north_ff, up_ff;

   // saturate Q16 millimetres to whole millimetres
   function automatic logic signed [34:0] finish_mm(input logic signed [63:0] q);
      logic signed [63:0] mm;
      mm = (q + 64'sd32768) >>> 16;
      if (mm > OUT_LIMIT) mm = OUT_LIMIT;
      if (mm < -OUT_LIMIT) mm = -OUT_LIMIT;
      return mm[34:0];
   endfunction

   // hold the whole pipeline while a finished word is stalled
   assign req_stall = valid_ff[LAT-1] & rsp_stall;
   assign adv       = !req_stall;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // reference registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_latitude_ff  <= '0;
         ref_longitude_ff <= '0;
         ref_altitude_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REF_LATITUDE: begin
               ref_latitude_ff <= csr_data[30:0];
            end
            CSR_REF_LONGITUDE: begin
               ref_longitude_ff <= csr_data;
            end
            CSR_REF_ALTITUDE: begin
               ref_altitude_ff <= csr_data[27:0];
            end
            default: begin
               ref_latitude_ff <= ref_latitude_ff;
            end
         endcase
      end
   end

   // trig of point and reference
   g2e_sincos #(.ITERS(ANGLE_ITERATIONS)) u_pt_lat (
      .clock(clock), .en(adv), .angle({req_latitude[30], req_latitude}), .trig(pt_lat));
   g2e_sincos #(.ITERS(ANGLE_ITERATIONS)) u_pt_lon (
      .clock(clock), .en(adv), .angle(req_longitude), .trig(pt_lon));
   g2e_sincos #(.ITERS(ANGLE_ITERATIONS)) u_rf_lat (
      .clock(clock), .en(adv), .angle({ref_latitude_ff[30], ref_latitude_ff}),
      .trig(rf_lat));
   g2e_sincos #(.ITERS(ANGLE_ITERATIONS)) u_rf_lon (
      .clock(clock), .en(adv), .angle(ref_longitude_ff), .trig(rf_lon));

   g2e_delay #(.WIDTH(28), .DEPTH(T_SC)) u_pt_alt (
      .clock(clock), .en(adv), .d(req_altitude), .q(pt_alt_d));
   g2e_delay #(.WIDTH(28), .DEPTH(T_SC)) u_rf_alt (
      .clock(clock), .en(adv), .d(ref_altitude_ff), .q(rf_alt_d));

   // Earth-centred positions
   g2e_ecef u_pt_ecef (
      .clock(clock), .en(adv), .trig_lat(pt_lat), .trig_lon(pt_lon), .alt(pt_alt_d),
      .pos_x(pp_x), .pos_y(pp_y), .pos_z(pp_z));
   g2e_ecef u_rf_ecef (
      .clock(clock), .en(adv), .trig_lat(rf_lat), .trig_lon(rf_lon), .alt(rf_alt_d),
      .pos_x(rp_x), .pos_y(rp_y), .pos_z(rp_z));

   // offset from the reference
   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff <= pp_x - rp_x;
         d1_ff <= pp_y - rp_y;
         d2_ff <= pp_z - rp_z;
      end
   end

   // reference trig: {sin lat, cos lat, sin lon, cos lon}
   g2e_delay #(.WIDTH(256), .DEPTH(ECEF_LAT + 1 - FL)) u_rt_early (
      .clock(clock), .en(adv),
      .d({rf_lat.sin_val, rf_lat.cos_val, rf_lon.sin_val, rf_lon.cos_val}),
      .q(rt_early));
   g2e_delay #(.WIDTH(256), .DEPTH(FL)) u_rt_late (
      .clock(clock), .en(adv), .d(rt_early), .q(rt_late));

   // rotation coefficients
   g2e_fmul #(.SHIFT(60)) u_spcl (
      .clock(clock), .en(adv), .a(rt_early[255:192]), .b(rt_early[63:0]), .y(spcl));
   g2e_fmul #(.SHIFT(60)) u_spsl (
      .clock(clock), .en(adv), .a(rt_early[255:192]), .b(rt_early[127:64]), .y(spsl));
   g2e_fmul #(.SHIFT(60)) u_cpcl (
      .clock(clock), .en(adv), .a(rt_early[191:128]), .b(rt_early[63:0]), .y(cpcl));
   g2e_fmul #(.SHIFT(60)) u_cpsl (
      .clock(clock), .en(adv), .a(rt_early[191:128]), .b(rt_early[127:64]), .y(cpsl));

   // rotate into east, north, up
   g2e_fmul #(.SHIFT(60)) u_e0 (
      .clock(clock), .en(adv), .a(rt_late[127:64]), .b(d0_ff), .y(e0));
   g2e_fmul #(.SHIFT(60)) u_e1 (
      .clock(clock), .en(adv), .a(rt_late[63:0]), .b(d1_ff), .y(e1));
   g2e_fmul #(.SHIFT(60)) u_n0 (.clock(clock), .en(adv), .a(spcl), .b(d0_ff), .y(n0));
   g2e_fmul #(.SHIFT(60)) u_n1 (.clock(clock), .en(adv), .a(spsl), .b(d1_ff), .y(n1));
   g2e_fmul #(.SHIFT(60)) u_n2 (
      .clock(clock), .en(adv), .a(rt_late[191:128]), .b(d2_ff), .y(n2));
   g2e_fmul #(.SHIFT(60)) u_u0 (.clock(clock), .en(adv), .a(cpcl), .b(d0_ff), .y(u0));
   g2e_fmul #(.SHIFT(60)) u_u1 (.clock(clock), .en(adv), .a(cpsl), .b(d1_ff), .y(u1));
   g2e_fmul #(.SHIFT(60)) u_u2 (
      .clock(clock), .en(adv), .a(rt_late[255:192]), .b(d2_ff), .y(u2));

   // sum the terms, then round and clamp into the output word
   always_ff @(posedge clock) begin
      if (adv) begin
         e_sum_ff <= e1 - e0;
         n_sum_ff <= n2 - n0 - n1;
         u_sum_ff <= u0 + u1 + u2;
         east_ff  <= finish_mm(e_sum_ff);
         north_ff <= finish_mm(n_sum_ff);
         up_ff    <= finish_mm(u_sum_ff);
      end
   end

   assign rsp_east  = east_ff;
   assign rsp_north = north_ff;
   assign rsp_up    = up_ff;

   `ASSERT_IMPLIES(a_stall_only_on_word, clock, reset, req_stall, rsp_valid)
   `ASSERT_NEXT(a_word_reaches_output, clock, reset, adv && valid_ff[LAT-2], rsp_valid)
   `ASSERT_IMPLIES(a_east_in_range, clock, reset, rsp_valid, (rsp_east <= OUT_LIMIT_35) && (rsp_east >= -OUT_LIMIT_35))
   `ASSERT_IMPLIES(a_up_in_range, clock, reset, rsp_valid, (rsp_up <= OUT_LIMIT_35) && (rsp_up >= -OUT_LIMIT_35))

endmodule

### dv/tb_geodetic_to_enu.sv
// Self-checking testbench for geodetic_to_enu: a bit-exact fixed-point predictor
// (CORDIC, Newton rsqrt, ECEF, ENU rotation) feeds a scoreboard of expected words.
// Depends on g2e_pkg and the geodetic_to_enu RTL.
module tb_geodetic_to_enu;
   import g2e_pkg::*;

   typedef enum logic [1:0] {
      REG_REF_LATITUDE  = 2'd0,
      REG_REF_LONGITUDE = 2'd1,
      REG_REF_ALTITUDE  = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef struct {
      logic signed [34:0] east;
      logic signed [34:0] north;
      logic signed [34:0] up;
   } enu_word_type;

   localparam int  ITERS      = 32;
   localparam int  DRAIN_WAIT = 260;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint Q60      = 64'sh1000_0000_0000_0000;
   localparam longint MM_LIMIT = 64'sd13000000000;
   localparam longint SEMI_Q16 = 64'sd6378137000 * 65536;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [30:0] req_latitude = '0;
   logic signed [31:0] req_longitude = '0;
   logic signed [27:0] req_altitude = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [34:0] rsp_east;
   logic signed [34:0] rsp_north;
   logic signed [34:0] rsp_up;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = REG_REF_LATITUDE;
   logic [31:0]        csr_data = '0;

   geodetic_to_enu u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // derived constants of the converter
   longint arctan_q60 [ITERS];
   longint cordic_gain_inv;
   longint ecc_sq;

   // round(a*b/2^s), magnitude half away from zero, saturating
   function automatic longint mul_round(longint a, longint b, int s);
      logic         neg;
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] prod;
      logic [63:0]  mag;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? 64'd0 - a : a;
      ub   = (b < 0) ? 64'd0 - b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = (prod + (128'd1 << (s - 1))) >> s;
      mag  = (|prod[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : prod[63:0];
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint inv_sqrt(longint v, longint y);
      longint t;
      for (int k = 0; k < 6; k++) begin
         t = mul_round(v, mul_round(y, y, 60), 60);
         y = mul_round(y, 3 * Q60 - t, 61);
      end
      return y;
   endfunction

   function automatic longint sign_extend(logic [63:0] v, int w);
      longint t;
      t = longint'(v << (64 - w));
      return t >>> (64 - w);
   endfunction

   function automatic void build_constants();
      longint p;
      longint sum;
      int     m;
      arctan_q60[0] = longint'((PI_Q60 + 64'd2) >> 2);
      for (int i = 1; i < ITERS; i++) begin
         sum = 0;
         for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
            m = 2 * k + 1;
            if (k % 2 == 1) sum -= longint'((64'd1 << (60 - m * i)) / m);
            else sum += longint'((64'd1 << (60 - m * i)) / m);
         end
         arctan_q60[i] = sum;
      end
      p = Q60;
      for (int i = 0; i < ITERS; i++)
         if (2 * i < 62) p += p >>> (2 * i);
      cordic_gain_inv = inv_sqrt(p, (3 * Q60) / 5);
      ecc_sq = mul_round(FLAT_Q60, 2 * Q60 - FLAT_Q60, 60);
   endfunction

   // sine and cosine in Q60 of an angle in 1e-7 degree
   function automatic void angle_trig(longint v, output longint sn, output longint cs);
      logic   flip;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      flip = 1'b0;
      if (v > 900000000) begin
         v -= 1800000000;
         flip = 1'b1;
      end else if (v < -900000000) begin
         v += 1800000000;
         flip = 1'b1;
      end
      z = mul_round(v, longint'(RAD_K), 32);
      x = cordic_gain_inv;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_q60[i];
         end else begin
            x += dx; y -= dy; z += arctan_q60[i];
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   // ECEF in Q16 millimetres
   function automatic void ecef_q16(longint slat, longint clat, longint slon, longint clon,
                                    longint alt, output longint px, output longint py,
                                    output longint pz);
      longint w;
      longint nr;
      longint h;
      longint rc;
      w  = Q60 - mul_round(ecc_sq, mul_round(slat, slat, 60), 60);
      nr = mul_round(SEMI_Q16, inv_sqrt(w, Q60), 60);
      h  = alt * 65536;
      rc = mul_round(nr + h, clat, 60);
      px = mul_round(rc, clon, 60);
      py = mul_round(rc, slon, 60);
      pz = mul_round(mul_round(nr, Q60 - ecc_sq, 60) + h, slat, 60);
   endfunction

   function automatic logic signed [34:0] round_to_mm(longint q16);
      longint mm;
      mm = (q16 + 32768) >>> 16;
      if (mm > MM_LIMIT) mm = MM_LIMIT;
      if (mm < -MM_LIMIT) mm = -MM_LIMIT;
      return mm[34:0];
   endfunction

   class enu_scoreboard;
      longint       ref_lat;
      longint       ref_lon;
      longint       ref_alt;
      enu_word_type pending_enu[$];
      int           errors;

      function new();
         ref_lat = 0; ref_lon = 0; ref_alt = 0; errors = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] data);
         case (idx)
            REG_REF_LATITUDE:  ref_lat = sign_extend(data, 31);
            REG_REF_LONGITUDE: ref_lon = sign_extend(data, 32);
            REG_REF_ALTITUDE:  ref_alt = sign_extend(data, 28);
            default: ;
         endcase
      endfunction

      // predict the ENU word for an accepted position
      function void note_word(longint lat, longint lon, longint alt);
         longint       pt[4];
         longint       rt[4];
         longint       pp[3];
         longint       rp[3];
         longint       d[3];
         longint       spcl, spsl, cpcl, cpsl, e, n, u;
         enu_word_type w;
         angle_trig(lat, pt[0], pt[1]);
         angle_trig(lon, pt[2], pt[3]);
         angle_trig(ref_lat, rt[0], rt[1]);
         angle_trig(ref_lon, rt[2], rt[3]);
         ecef_q16(pt[0], pt[1], pt[2], pt[3], alt, pp[0], pp[1], pp[2]);
         ecef_q16(rt[0], rt[1], rt[2], rt[3], ref_alt, rp[0], rp[1], rp[2]);
         for (int i = 0; i < 3; i++) d[i] = pp[i] - rp[i];
         spcl = mul_round(rt[0], rt[3], 60);
         spsl = mul_round(rt[0], rt[2], 60);
         cpcl = mul_round(rt[1], rt[3], 60);
         cpsl = mul_round(rt[1], rt[2], 60);
         e = -mul_round(rt[2], d[0], 60) + mul_round(rt[3], d[1], 60);
         n = -mul_round(spcl, d[0], 60) - mul_round(spsl, d[1], 60)
             + mul_round(rt[1], d[2], 60);
         u = mul_round(cpcl, d[0], 60) + mul_round(cpsl, d[1], 60)
             + mul_round(rt[0], d[2], 60);
         w.east  = round_to_mm(e);
         w.north = round_to_mm(n);
         w.up    = round_to_mm(u);
         pending_enu.push_back(w);
      endfunction

      function void check_word(logic signed [34:0] e, logic signed [34:0] n,
                               logic signed [34:0] u);
         enu_word_type w;
         if (pending_enu.size() == 0) begin
            $error("unexpected word: east %0d north %0d up %0d", e, n, u);
            errors++;
            return;
         end
         w = pending_enu.pop_front();
         if (e !== w.east) begin
            $error("east: expected %0d, got %0d", w.east, e);
            errors++;
         end
         if (n !== w.north) begin
            $error("north: expected %0d, got %0d", w.north, n);
            errors++;
         end
         if (u !== w.up) begin
            $error("up: expected %0d, got %0d", w.up, u);
            errors++;
         end
      endfunction
   endclass

   enu_scoreboard sb = new();
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   bit     hold_request = 1'b0;
   int     hold_left = 0;
   longint cycle_count = 0;

   // receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 600;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // check each accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_east, rsp_north, rsp_up);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(longint lat, longint lon, longint alt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_latitude  <= lat[30:0];
      req_longitude <= lon[31:0];
      req_altitude  <= alt[27:0];
      do @(posedge clock); while (req_stall);
      sb.note_word(sign_extend(lat, 31), sign_extend(lon, 32), sign_extend(alt, 28));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_enu.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // raise the write for one cycle; the caller drops the enable after the last write
   task automatic write_reg(reg_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic set_reference(longint lat, longint lon, longint alt);
      write_reg(REG_REF_LATITUDE, lat[31:0]);
      write_reg(REG_REF_LONGITUDE, lon[31:0]);
      write_reg(REG_REF_ALTITUDE, alt[31:0]);
   endtask

   // mostly in range, sometimes any bit pattern of the field
   task automatic send_random();
      longint lat, lon, alt;
      if ($urandom_range(9) == 0) begin
         lat = sign_extend($urandom, 31);
         lon = sign_extend($urandom, 32);
         alt = sign_extend($urandom, 28);
      end else begin
         lat = longint'($urandom_range(1800000000)) - 900000000;
         lon = longint'($urandom_range(3600000000)) - 1800000000;
         alt = longint'($urandom_range(101000000)) - 1000000;
      end
      send_word(lat, lon, alt);
   endtask

   int idle_tab  [6] = '{0, 88, 0, 21, 0, 88};
   int stall_tab [6] = '{0, 0, 88, 21, 0, 88};

   initial begin
      build_constants();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes and special cases at the reset reference
      send_word(0, 0, 0);
      send_word(900000000, 0, 0);
      send_word(-900000000, 0, 0);
      send_word(1073741823, 0, 0);
      send_word(-1073741824, 0, 0);
      send_word(0, 1800000000, 0);
      send_word(0, -1800000000, 0);
      send_word(0, 2147483647, 0);
      send_word(0, -2147483648, 0);
      send_word(0, 900000000, 100000000);
      send_word(0, 0, 134217727);
      send_word(0, 0, -134217728);
      send_word(0, 0, -1000000);
      send_word(450000000, 1200000000, 100000000);
      send_word(-1073741824, -2147483648, -134217728);
      send_word(1073741823, 2147483647, 134217727);
      drain();

      // random phases over several references
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = idle_tab[ph];
         stall_pct     = stall_tab[ph];
         case (ph)
            0: set_reference(900000000, 1800000000, 100000000);
            1: set_reference(-900000000, -1800000000, -1000000);
            2: set_reference(sign_extend($urandom, 31), sign_extend($urandom, 32),
                             sign_extend($urandom, 28));
            3: set_reference(1073741823, -2147483648, 134217727);
            default: set_reference(longint'($urandom_range(1800000000)) - 900000000,
                                   longint'($urandom_range(3600000000)) - 1800000000,
                                   longint'($urandom_range(101000000)) - 1000000);
         endcase
         // ignored index must not disturb the reference
         write_reg(REG_UNUSED, $urandom);
         csr_write_enable <= 1'b0;
         if (ph == 0) send_word(-1000, -2000, 5);
         if (ph == 4) begin
            // long receiver hold-off while the sender keeps pushing
            hold_request = 1'b1;
            repeat (400) send_random();
            drain();
         end
         repeat (100) send_random();
         drain();
      end

      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
